// ===== hw/rtl/piq_pkg.sv =====
package piq_pkg;

    localparam int DEPTH = 64;
    localparam int ID_W  = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_POS    = 3'd2;
    localparam logic [OP_W-1:0] OP_SERVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [ID_W-1:0]  client_id;
        logic [CNT_W-1:0] position;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  removed_id;
        logic [CNT_W-1:0] count;
    } t_out_word;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_INS  = 2'd1,
        ACT_DEL  = 2'd2
    } t_act;

    typedef struct packed {
        t_act             act;
        logic             cmp;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] count;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/piq_cell.sv =====
module piq_cell (
    input  logic                        i_clk,
    input  piq_pkg::t_cell_ctl          i_ctl,
    input  logic [piq_pkg::IDX_W-1:0]   i_idx,
    input  logic                        i_del,
    input  logic [piq_pkg::ID_W-1:0]    i_left,
    input  logic [piq_pkg::ID_W-1:0]    i_right,
    output logic [piq_pkg::ID_W-1:0]    o_value,
    output logic                        o_match
);

    logic [piq_pkg::ID_W-1:0]  r_value;
    logic [piq_pkg::ID_W-1:0]  n_value;
    logic                      r_match;
    logic [piq_pkg::CNT_W-1:0] w_idx;

    assign w_idx = piq_pkg::CNT_W'(i_idx);

    always_comb begin
        n_value = r_value;
        case (i_ctl.act)
            piq_pkg::ACT_INS: begin
                if (w_idx == i_ctl.pos) begin
                    n_value = i_ctl.id;
                end else if (w_idx > i_ctl.pos) begin
                    n_value = i_left;
                end
            end
            piq_pkg::ACT_DEL: begin
                if (i_del) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.cmp) begin
            r_match <= (r_value == i_ctl.id) && (w_idx < i_ctl.count);
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ===== hw/rtl/positional_insert_queue.sv =====
// positional_insert_queue: ordered queue of 16-bit client ids held in a row
// of shift cells, 64 deep, with an entry count.
// input channel (i_in_valid / o_in_ready / i_in_word): one command word with
// operation, client_id and position. output channel (o_out_valid /
// i_out_ready / o_out_word): one result word per command with status,
// removed_id and the count after the command.
// one command is in the block at a time: accept, compare state (every cell
// checks its id against the command), execute state (every cell shifts,
// loads or holds at once). the result is registered when the execute state
// completes, and the next command can be accepted only after that; the
// compare and execute steps are the same for every position and count.
// if the receiver stalls, the finished result holds in the output register
// and the next command waits in its execute state until the register frees.
// reset empties the queue (count zero) and drops any pending result; cell
// contents are not cleared, cells above the count are never read.
module positional_insert_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  piq_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output piq_pkg::t_out_word   o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    piq_pkg::t_in_word            r_cmd;
    logic [piq_pkg::CNT_W-1:0]    r_count;
    logic [piq_pkg::CNT_W-1:0]    n_count;
    logic                         r_out_valid;
    piq_pkg::t_out_word           r_out_word;

    piq_pkg::t_cell_ctl           w_ctl;
    piq_pkg::t_act                w_act;
    logic [piq_pkg::CNT_W-1:0]    w_pos;
    logic [piq_pkg::ST_W-1:0]     w_status;
    logic [piq_pkg::ID_W-1:0]     w_removed;
    logic [piq_pkg::DEPTH-1:0]    w_del;
    logic [piq_pkg::DEPTH-1:0]    w_pick;
    logic [piq_pkg::DEPTH-1:0]    w_match;
    logic [piq_pkg::DEPTH-1:0]    w_low;
    logic [piq_pkg::DEPTH-1:0]    w_ge;
    logic [piq_pkg::DEPTH-1:0]    w_is_last;
    logic [piq_pkg::ID_W-1:0]     w_value [piq_pkg::DEPTH];
    logic                         w_fire;
    logic                         w_accept;
    logic                         w_full;
    logic                         w_empty;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign w_full     = (r_count == piq_pkg::CNT_W'(piq_pkg::DEPTH));
    assign w_empty    = (r_count == '0);

    // lowest match and the cells from it upwards
    assign w_low = w_match & (~w_match + piq_pkg::DEPTH'(1));
    assign w_ge  = ~((w_match - piq_pkg::DEPTH'(1)) & ~w_match);

    genvar g;
    generate
        for (g = 0; g < piq_pkg::DEPTH; g++) begin : g_cell
            logic [piq_pkg::ID_W-1:0] w_left;
            logic [piq_pkg::ID_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_value[g-1];
            end
            if (g == piq_pkg::DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_value[g+1];
            end
            assign w_is_last[g] = (piq_pkg::CNT_W'(g + 1) == r_count);

            piq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_idx   (piq_pkg::IDX_W'(g)),
                .i_del   (w_del[g]),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_value[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    always_comb begin
        w_act    = piq_pkg::ACT_HOLD;
        w_pos    = '0;
        w_status = piq_pkg::ST_OK;
        w_del    = '0;
        w_pick   = '0;
        n_count  = r_count;
        case (r_cmd.operation)
            piq_pkg::OP_APPEND, piq_pkg::OP_HEAD, piq_pkg::OP_POS: begin
                if (w_full) begin
                    w_status = piq_pkg::ST_FULL;
                end else begin
                    w_act   = piq_pkg::ACT_INS;
                    n_count = r_count + piq_pkg::CNT_W'(1);
                    if (r_cmd.operation == piq_pkg::OP_APPEND) begin
                        w_pos = r_count;
                    end else if (r_cmd.operation == piq_pkg::OP_HEAD) begin
                        w_pos = '0;
                    end else if (r_cmd.position > r_count) begin
                        w_pos = r_count;
                    end else begin
                        w_pos = r_cmd.position;
                    end
                end
            end
            piq_pkg::OP_SERVE: begin
                if (w_empty) begin
                    w_status = piq_pkg::ST_EMPTY;
                end else begin
                    w_act   = piq_pkg::ACT_DEL;
                    w_del   = '1;
                    w_pick  = piq_pkg::DEPTH'(1);
                    n_count = r_count - piq_pkg::CNT_W'(1);
                end
            end
            piq_pkg::OP_DROP: begin
                if (w_empty) begin
                    w_status = piq_pkg::ST_EMPTY;
                end else begin
                    w_pick  = w_is_last;
                    n_count = r_count - piq_pkg::CNT_W'(1);
                end
            end
            piq_pkg::OP_REMOVE: begin
                if (w_empty) begin
                    w_status = piq_pkg::ST_EMPTY;
                end else if (w_match == '0) begin
                    w_status = piq_pkg::ST_NOTFOUND;
                end else begin
                    w_act   = piq_pkg::ACT_DEL;
                    w_del   = w_ge;
                    w_pick  = w_low;
                    n_count = r_count - piq_pkg::CNT_W'(1);
                end
            end
            default: begin
                w_status = piq_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        w_removed = '0;
        for (int k = 0; k < piq_pkg::DEPTH; k++) begin
            w_removed = w_removed | (w_value[k] & {piq_pkg::ID_W{w_pick[k]}});
        end
    end

    always_comb begin
        w_ctl.act   = w_fire ? w_act : piq_pkg::ACT_HOLD;
        w_ctl.cmp   = (r_state == S_CMP);
        w_ctl.id    = r_cmd.client_id;
        w_ctl.pos   = w_pos;
        w_ctl.count = r_count;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_word;
        end
        if (w_fire) begin
            r_out_word.status     <= w_status;
            r_out_word.removed_id <= w_removed;
            r_out_word.count      <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= piq_pkg::CNT_W'(piq_pkg::DEPTH))
        else $error("entry count above depth");

    a_count_on_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_count))
        else $error("count moved without a result word");

    a_word_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result word raised outside execute");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CMP))
        else $error("accepted word did not start a compare");
`endif

endmodule

// ===== tb/tb_positional_insert_queue.sv =====
module tb_positional_insert_queue;

    localparam int RUN_ITEMS     = 800;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_REPORTS   = 10;

    localparam logic [piq_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [piq_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } t_rx_mode;

    class client_queue_sb;
        logic [piq_pkg::ID_W-1:0] clients[$];
        piq_pkg::t_out_word       expected_results[$];
        int mismatches;
        int checked;
        int commands;
        int full_refusals;
        int empty_refusals;
        int misses;
        int peak;

        function new();
            mismatches     = 0;
            checked        = 0;
            commands       = 0;
            full_refusals  = 0;
            empty_refusals = 0;
            misses         = 0;
            peak           = 0;
        endfunction

        function void note_command(piq_pkg::t_in_word w);
            piq_pkg::t_out_word r;
            int slot;
            int i;
            bit found;
            r.status     = piq_pkg::ST_OK;
            r.removed_id = '0;
            found        = 1'b0;
            case (w.operation)
                piq_pkg::OP_APPEND, piq_pkg::OP_HEAD, piq_pkg::OP_POS: begin
                    if (clients.size() >= piq_pkg::DEPTH) begin
                        r.status = piq_pkg::ST_FULL;
                        full_refusals++;
                    end else if (w.operation == piq_pkg::OP_APPEND) begin
                        clients.push_back(w.client_id);
                    end else if (w.operation == piq_pkg::OP_HEAD) begin
                        clients.push_front(w.client_id);
                    end else begin
                        slot = int'(w.position);
                        if (slot > clients.size())
                            slot = clients.size();
                        clients.insert(slot, w.client_id);
                    end
                end
                piq_pkg::OP_SERVE, piq_pkg::OP_DROP, piq_pkg::OP_REMOVE: begin
                    if (clients.size() == 0) begin
                        r.status = piq_pkg::ST_EMPTY;
                        empty_refusals++;
                    end else if (w.operation == piq_pkg::OP_SERVE) begin
                        r.removed_id = clients.pop_front();
                    end else if (w.operation == piq_pkg::OP_DROP) begin
                        r.removed_id = clients.pop_back();
                    end else begin
                        for (i = 0; i < clients.size() && !found; i++) begin
                            if (clients[i] == w.client_id) begin
                                r.removed_id = clients[i];
                                clients.delete(i);
                                found = 1'b1;
                            end
                        end
                        if (!found) begin
                            r.status = piq_pkg::ST_NOTFOUND;
                            misses++;
                        end
                    end
                end
                default: ;
            endcase
            r.count = piq_pkg::CNT_W'(clients.size());
            if (clients.size() > peak)
                peak = clients.size();
            commands++;
            expected_results.push_back(r);
        endfunction

        function void check_result(piq_pkg::t_out_word got);
            piq_pkg::t_out_word want;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: status %0d id %h count %0d",
                             got.status, got.removed_id, got.count);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.removed_id !== want.removed_id ||
                got.count !== want.count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"word %0d: expected status %0d id %h count %0d, ",
                              "got status %0d id %h count %0d"},
                             checked, want.status, want.removed_id, want.count,
                             got.status, got.removed_id, got.count);
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    piq_pkg::t_in_word  in_word   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    piq_pkg::t_out_word out_word;

    int       cycle_cnt  = 0;
    int       burst_left = 0;
    int       mode_left  = 0;
    int       rand_sent  = 0;
    t_rx_mode rx_mode    = RX_OPEN;

    client_queue_sb sb = new();

    positional_insert_queue i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // receiver stall pattern, switching between styles now and then
    always @(posedge clk) begin
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(40, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     out_ready <= 1'b1;
            RX_RANDOM:   out_ready <= ($urandom_range(0, 9) < 6);
            RX_PERIODIC: out_ready <= ((cycle_cnt % 5) != 0);
            default:     out_ready <= ($urandom_range(0, 15) == 0) ? ~out_ready : out_ready;
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word);
    end

    function automatic piq_pkg::t_in_word make_word(logic [piq_pkg::OP_W-1:0] op,
                                                    logic [piq_pkg::ID_W-1:0] id,
                                                    int pos);
        piq_pkg::t_in_word w;
        w.operation = op;
        w.client_id = id;
        w.position  = piq_pkg::CNT_W'(pos);
        return w;
    endfunction

    function automatic logic [piq_pkg::ID_W-1:0] pick_id(bit hunt);
        logic [piq_pkg::ID_W-1:0] v;
        v = piq_pkg::ID_W'($urandom);
        if (hunt && sb.clients.size() != 0 && $urandom_range(0, 9) < 7)
            v = sb.clients[$urandom_range(0, sb.clients.size() - 1)];
        else begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                2, 3, 4: v = piq_pkg::ID_W'($urandom_range(0, 7));
                default: ;
            endcase
        end
        return v;
    endfunction

    function automatic piq_pkg::t_in_word rand_word(int insert_pct);
        piq_pkg::t_in_word w;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            w.operation = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end else if (roll < 3 + insert_pct * 97 / 100) begin
            case ($urandom_range(0, 2))
                0:       w.operation = piq_pkg::OP_APPEND;
                1:       w.operation = piq_pkg::OP_HEAD;
                default: w.operation = piq_pkg::OP_POS;
            endcase
        end else begin
            case ($urandom_range(0, 2))
                0:       w.operation = piq_pkg::OP_SERVE;
                1:       w.operation = piq_pkg::OP_DROP;
                default: w.operation = piq_pkg::OP_REMOVE;
            endcase
        end
        w.client_id = pick_id(w.operation == piq_pkg::OP_REMOVE);
        case ($urandom_range(0, 4))
            0:       w.position = piq_pkg::CNT_W'($urandom_range(0, 127));
            1:       w.position = piq_pkg::CNT_W'($urandom_range(0, piq_pkg::DEPTH));
            default: w.position = piq_pkg::CNT_W'($urandom_range(0, sb.clients.size()));
        endcase
        return w;
    endfunction

    task automatic send_word(input piq_pkg::t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_command(w);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
    endtask

    initial begin
        int phase;
        int pct;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // removals and spare codes on an empty queue
        send_word(make_word(piq_pkg::OP_SERVE, 16'h0000, 0));
        send_word(make_word(piq_pkg::OP_DROP, 16'hffff, 0));
        send_word(make_word(piq_pkg::OP_REMOVE, 16'h0000, 0));
        send_word(make_word(OP_SPARE_A, 16'h1234, 5));
        // inserts at both ends and at positions at, inside and past the count
        send_word(make_word(piq_pkg::OP_APPEND, 16'hffff, 0));
        send_word(make_word(piq_pkg::OP_APPEND, 16'h0000, 127));
        send_word(make_word(piq_pkg::OP_HEAD, 16'h8000, 0));
        send_word(make_word(piq_pkg::OP_POS, 16'h1234, 0));
        send_word(make_word(piq_pkg::OP_POS, 16'h00ff, 127));
        send_word(make_word(piq_pkg::OP_POS, 16'h5555, piq_pkg::DEPTH));
        send_word(make_word(piq_pkg::OP_POS, 16'haaaa, 6));
        send_word(make_word(piq_pkg::OP_POS, 16'h0001, 2));
        send_word(make_word(piq_pkg::OP_POS, 16'h7f80, 1));
        // remove by id: hit, miss, first of duplicates
        send_word(make_word(piq_pkg::OP_REMOVE, 16'h0000, 0));
        send_word(make_word(piq_pkg::OP_REMOVE, 16'h7777, 0));
        send_word(make_word(piq_pkg::OP_APPEND, 16'hffff, 0));
        send_word(make_word(piq_pkg::OP_REMOVE, 16'hffff, 0));
        send_word(make_word(piq_pkg::OP_REMOVE, 16'haaaa, 0));
        send_word(make_word(piq_pkg::OP_SERVE, 16'h0000, 0));
        send_word(make_word(piq_pkg::OP_DROP, 16'h0000, 0));
        send_word(make_word(OP_SPARE_B, 16'hffff, 127));
        wait_idle();

        // alternate fill, drain and mixed phases so full and empty are both reached
        phase = 0;
        while (rand_sent < RUN_ITEMS) begin
            case (phase % 3)
                0:       pct = 85;
                1:       pct = 15;
                default: pct = 50;
            endcase
            repeat ($urandom_range(60, 140)) begin
                send_word(rand_word(pct));
                rand_sent++;
            end
            if ($urandom_range(0, 2) == 0)
                wait_idle();
            phase++;
        end
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d commands, %0d result words checked, peak occupancy %0d of %0d",
                 sb.commands, sb.checked, sb.peak, piq_pkg::DEPTH);
        $display("refused %0d inserts when full and %0d removals when empty, %0d id misses",
                 sb.full_refusals, sb.empty_refusals, sb.misses);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words outstanding",
                 cycle_cnt, sb.expected_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
